@@ sv/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

    localparam int unsigned LimitW   = 16;
    localparam int unsigned CountW   = 17;
    localparam int unsigned QDepth   = 4;
    localparam int unsigned QPtrW    = $clog2(QDepth);
    localparam logic [LimitW-1:0] LimitReset = 16'd127;

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChU      = 8'h75;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChTab    = 8'h09;

    typedef enum logic [1:0] {
        MODE_DONE,
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX
    } t_mode;

    typedef enum logic [1:0] {
        END_QUOTE = 2'd0,
        END_ZERO  = 2'd1,
        END_LIMIT = 2'd2,
        END_BAD   = 2'd3
    } t_end_reason;

    typedef struct packed {
        logic             is_end;
        t_end_reason      reason;
        logic [1:0]       nbytes;
        logic [2:0][7:0]  bytes;
    } t_job;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/jsu_if.sv @@
`default_nettype none
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] in_byte;

    modport source (output valid, output start_req, output in_byte, input ready);
    modport sink   (input valid, input start_req, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_end;
    logic [1:0] end_reason;
    logic       last;

    modport source (output valid, output out_byte, output is_end, output end_reason,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input is_end, input end_reason,
                    input last, output ready);
endinterface
`default_nettype wire

@@ sv/jsu_front.sv @@
`default_nettype none
module jsu_front
    import jsu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_start_req,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic [LimitW-1:0] i_out_limit,
    input  wire logic              i_q_full,
    output logic                   o_ready,
    output logic                   o_push,
    output t_job                   o_job
);

    t_mode              r_mode, n_mode;
    logic [15:0]        r_acc, n_acc;
    logic [1:0]         r_hex_cnt, n_hex_cnt;
    logic [CountW-1:0]  r_count, n_count;

    t_mode              cur_mode;
    logic [15:0]        base_acc;
    logic [1:0]         base_hex;
    logic [CountW-1:0]  base_count;
    logic [15:0]        cp;
    logic               accept;
    logic               limit_hit;
    t_job               job;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;

    assign cur_mode   = i_start_req ? MODE_TEXT : r_mode;
    assign base_acc   = i_start_req ? 16'd0 : r_acc;
    assign base_hex   = i_start_req ? 2'd0 : r_hex_cnt;
    assign base_count = i_start_req ? '0 : r_count;
    assign cp         = {base_acc[11:0], hex_value(i_in_byte)};
    assign limit_hit  = base_count >= {1'b0, i_out_limit};

    // next mode
    always_comb begin
        n_mode = r_mode;
        if (accept) begin
            unique case (cur_mode)
                MODE_TEXT: begin
                    if (i_in_byte == 8'd0 || limit_hit || i_in_byte == ChQuote) begin
                        n_mode = MODE_DONE;
                    end else if (i_in_byte == ChBslash) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_mode = MODE_TEXT;
                    end
                end
                MODE_ESC: begin
                    if (i_in_byte == 8'd0) begin
                        n_mode = MODE_DONE;
                    end else if (i_in_byte == ChU) begin
                        n_mode = MODE_HEX;
                    end else begin
                        n_mode = MODE_TEXT;
                    end
                end
                MODE_HEX: begin
                    if (i_in_byte == 8'd0) begin
                        n_mode = MODE_DONE;
                    end else if (base_hex == 2'd3) begin
                        n_mode = MODE_TEXT;
                    end else begin
                        n_mode = MODE_HEX;
                    end
                end
                default: n_mode = MODE_DONE;
            endcase
        end
    end

    // job and datapath
    always_comb begin
        job        = '0;
        n_acc      = r_acc;
        n_hex_cnt  = r_hex_cnt;
        n_count    = r_count;
        if (accept) begin
            n_acc     = base_acc;
            n_hex_cnt = base_hex;
            unique case (cur_mode)
                MODE_TEXT: begin
                    if (i_in_byte == 8'd0) begin
                        job.is_end = 1'b1;
                        job.reason = END_ZERO;
                    end else if (limit_hit) begin
                        job.is_end = 1'b1;
                        job.reason = END_LIMIT;
                    end else if (i_in_byte == ChQuote) begin
                        job.is_end = 1'b1;
                        job.reason = END_QUOTE;
                    end else if (i_in_byte != ChBslash) begin
                        job.nbytes   = 2'd1;
                        job.bytes[0] = i_in_byte;
                    end
                end
                MODE_ESC: begin
                    if (i_in_byte == 8'd0) begin
                        job.is_end = 1'b1;
                        job.reason = END_BAD;
                    end else if (i_in_byte == ChU) begin
                        n_acc     = 16'd0;
                        n_hex_cnt = 2'd0;
                    end else begin
                        job.nbytes = 2'd1;
                        priority case (i_in_byte)
                            ChN:     job.bytes[0] = ChLf;
                            ChR:     job.bytes[0] = ChCr;
                            ChT:     job.bytes[0] = ChTab;
                            default: job.bytes[0] = i_in_byte;
                        endcase
                    end
                end
                MODE_HEX: begin
                    if (i_in_byte == 8'd0) begin
                        job.is_end = 1'b1;
                        job.reason = END_BAD;
                    end else begin
                        n_acc = cp;
                        if (base_hex == 2'd3) begin
                            n_hex_cnt = 2'd0;
                            if (cp <= 16'h007F) begin
                                job.nbytes   = 2'd1;
                                job.bytes[0] = cp[7:0];
                            end else if (cp <= 16'h07FF) begin
                                job.nbytes   = 2'd2;
                                job.bytes[0] = {3'b110, cp[10:6]};
                                job.bytes[1] = {2'b10, cp[5:0]};
                            end else begin
                                job.nbytes   = 2'd3;
                                job.bytes[0] = {4'b1110, cp[15:12]};
                                job.bytes[1] = {2'b10, cp[11:6]};
                                job.bytes[2] = {2'b10, cp[5:0]};
                            end
                        end else begin
                            n_hex_cnt = base_hex + 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
            n_count = base_count + {{(CountW-2){1'b0}}, job.nbytes};
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.is_end || job.nbytes != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_DONE;
            r_acc     <= 16'd0;
            r_hex_cnt <= 2'd0;
            r_count   <= '0;
        end else begin
            r_mode    <= n_mode;
            r_acc     <= n_acc;
            r_hex_cnt <= n_hex_cnt;
            r_count   <= n_count;
        end
    end

endmodule
`default_nettype wire

@@ sv/jsu_queue.sv @@
`default_nettype none
module jsu_queue
    import jsu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_job  i_job,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_job       o_head
);

    t_job              r_mem [QDepth];
    logic [QPtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QPtrW:0]    r_fill;

    assign o_full  = r_fill == (QPtrW+1)'(QDepth);
    assign o_empty = r_fill == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/jsu_back.sv @@
`default_nettype none
module jsu_back
    import jsu_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_job  i_head,
    input  wire logic  i_ready,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_is_end,
    output logic [1:0] o_end_reason,
    output logic       o_last,
    output logic       o_pop
);

    logic [1:0] r_idx;
    logic       fire;

    assign o_valid      = !i_empty;
    assign o_is_end     = i_head.is_end;
    assign o_end_reason = i_head.is_end ? i_head.reason : END_QUOTE;
    assign o_last       = i_head.is_end || (r_idx == i_head.nbytes - 2'd1);
    assign fire         = o_valid && i_ready;
    assign o_pop        = fire && o_last;

    always_comb begin
        o_out_byte = 8'd0;
        if (!i_head.is_end) begin
            unique case (r_idx)
                2'd0:    o_out_byte = i_head.bytes[0];
                2'd1:    o_out_byte = i_head.bytes[1];
                2'd2:    o_out_byte = i_head.bytes[2];
                default: o_out_byte = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (fire) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule
`default_nettype wire

@@ sv/json_string_unescape_utf8_core.sv @@
`default_nettype none
// JSON string unescaper: feed the bytes of a string value starting after the opening
// quote, with start_req on the first one; it emits unescaped bytes (\uXXXX as 1 to 3
// UTF-8 bytes) and one end report when a value ends. A byte is taken every cycle while
// the four-entry job queue has room; the output side sends one result per cycle while
// the receiver is ready, so a \u escape producing three bytes takes three transfers.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    jsu_in_if.sink                 i_in,
    jsu_out_if.source              o_out,
    input  wire logic              i_cfg_we,
    input  wire logic [LimitW-1:0] i_cfg_data
);

    logic [LimitW-1:0] r_out_limit;
    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    t_job              job;
    t_job              head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit <= LimitReset;
        end else if (i_cfg_we) begin
            r_out_limit <= i_cfg_data;
        end
    end

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_start_req (i_in.start_req),
        .i_in_byte   (i_in.in_byte),
        .i_out_limit (r_out_limit),
        .i_q_full    (q_full),
        .o_ready     (i_in.ready),
        .o_push      (push),
        .o_job       (job)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (head),
        .i_ready      (o_out.ready),
        .o_valid      (o_out.valid),
        .o_out_byte   (o_out.out_byte),
        .o_is_end     (o_out.is_end),
        .o_end_reason (o_out.end_reason),
        .o_last       (o_out.last),
        .o_pop        (pop)
    );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        is_end;
        t_end_reason reason;
        logic        last;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [LimitW-1:0] cfg_data;

    jsu_in_if  in_if();
    jsu_out_if out_if();

    json_string_unescape_utf8_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // decoder state mirrored by the predictor
    t_mode             dec_mode;
    logic [15:0]       dec_code;
    logic [1:0]        dec_hexn;
    logic [CountW-1:0] dec_count;
    logic [LimitW-1:0] dec_limit;
    t_result           step_res [3];
    int                step_n;

    t_result decoded_q [$];
    int      errors;
    int      n_sent;
    int      src_idle_pct;
    int      snk_stall_pct;
    int      hold_cycles;
    string   hex_chars = "0123456789abcdefABCDEF";

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        step_res[step_n] = '{data: b, is_end: 1'b0, reason: END_QUOTE, last: 1'b0};
        step_n++;
        dec_count = dec_count + 1'b1;
    endtask

    task automatic emit_end(input t_end_reason why);
        step_res[step_n] = '{data: 8'h00, is_end: 1'b1, reason: why, last: 1'b0};
        step_n++;
        dec_mode = MODE_DONE;
    endtask

    task automatic decode_byte(input logic start, input logic [7:0] b);
        logic [15:0] cp;
        logic [7:0]  m;
        step_n = 0;
        if (start) begin
            dec_mode  = MODE_TEXT;
            dec_code  = '0;
            dec_hexn  = '0;
            dec_count = '0;
        end
        case (dec_mode)
            MODE_TEXT: begin
                if (b == 8'h00) emit_end(END_ZERO);
                else if (dec_count >= {1'b0, dec_limit}) emit_end(END_LIMIT);
                else if (b == ChQuote) emit_end(END_QUOTE);
                else if (b == ChBslash) dec_mode = MODE_ESC;
                else emit_byte(b);
            end
            MODE_ESC: begin
                if (b == 8'h00) begin
                    emit_end(END_BAD);
                end else if (b == ChU) begin
                    dec_mode = MODE_HEX;
                    dec_code = '0;
                    dec_hexn = '0;
                end else begin
                    case (b)
                        ChN:     m = ChLf;
                        ChR:     m = ChCr;
                        ChT:     m = ChTab;
                        default: m = b;
                    endcase
                    emit_byte(m);
                    dec_mode = MODE_TEXT;
                end
            end
            MODE_HEX: begin
                if (b == 8'h00) begin
                    emit_end(END_BAD);
                end else begin
                    cp = {dec_code[11:0], nibble_of(b)};
                    dec_code = cp;
                    if (dec_hexn == 2'd3) begin
                        dec_hexn = '0;
                        dec_mode = MODE_TEXT;
                        if (cp <= 16'h007F) begin
                            emit_byte(cp[7:0]);
                        end else if (cp <= 16'h07FF) begin
                            emit_byte({3'b110, cp[10:6]});
                            emit_byte({2'b10, cp[5:0]});
                        end else begin
                            emit_byte({4'b1110, cp[15:12]});
                            emit_byte({2'b10, cp[11:6]});
                            emit_byte({2'b10, cp[5:0]});
                        end
                    end else begin
                        dec_hexn = dec_hexn + 2'd1;
                    end
                end
            end
            default: dec_mode = MODE_DONE;
        endcase
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int k = 0; k < step_n; k++) decoded_q.push_back(step_res[k]);
    endtask

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    // one request; valid stays high into the next call unless a gap is inserted
    task automatic send(input logic start, input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(1, 3);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.start_req <= start;
        in_if.in_byte   <= b;
        do @(posedge i_clk); while (!in_if.ready);
        decode_byte(start, b);
        n_sent++;
    endtask

    task automatic send_text(input logic first_start, input string s);
        for (int i = 0; i < s.len(); i++) send(first_start && i == 0, s[i]);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LimitW-1:0] v);
        drain();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        dec_limit = v;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == ChQuote || b == ChBslash);
        return b;
    endfunction

    function automatic logic [7:0] escape_letter();
        logic [7:0] b;
        case ($urandom_range(6))
            0: b = ChN;
            1: b = ChR;
            2: b = ChT;
            3: b = ChQuote;
            4: b = ChBslash;
            5: b = 8'h2F;
            default: do b = 8'($urandom_range(1, 255)); while (b == ChU);
        endcase
        return b;
    endfunction

    function automatic logic [7:0] hex_char();
        if ($urandom_range(7) == 0) return 8'($urandom_range(1, 255));
        return hex_chars[$urandom_range(0, 21)];
    endfunction

    task automatic send_random_value(input int max_chars);
        int kind;
        int ndig;
        if ($urandom_range(9) == 0) send(1'b1, 8'($urandom_range(0, 255)));
        else send(1'b1, text_byte());
        repeat ($urandom_range(0, max_chars)) begin
            kind = $urandom_range(9);
            if (kind < 5) begin
                send(1'b0, text_byte());
            end else if (kind < 8) begin
                send(1'b0, ChBslash);
                send(1'b0, escape_letter());
            end else begin
                send(1'b0, ChBslash);
                send(1'b0, ChU);
                repeat (4) send(1'b0, hex_char());
            end
        end
        kind = $urandom_range(9);
        if (kind < 6) begin
            send(1'b0, ChQuote);
        end else if (kind == 6) begin
            send(1'b0, 8'h00);
        end else if (kind == 7) begin
            send(1'b0, ChBslash);
            send(1'b0, 8'h00);
        end else if (kind == 8) begin
            ndig = $urandom_range(0, 3);
            send(1'b0, ChBslash);
            send(1'b0, ChU);
            repeat (ndig) send(1'b0, hex_char());
            send(1'b0, 8'h00);
        end
        // otherwise the next start cuts the value off
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) send(1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_special_cases();
        send(1'b0, 8'hA5);
        send_text(1'b1, "\\n\\r\\t\\\"\\\\\\/\\");
        send(1'b0, 8'hFF);
        send_text(1'b0, "\\u00e9\\uFfx0\"");
        send(1'b0, 8'h01);
        send(1'b1, 8'h00);
        send_text(1'b1, "\\");
        send(1'b0, 8'h00);
        send_text(1'b1, "\\u1");
        send(1'b0, 8'h00);
        drain();
    endtask

    task automatic test_default_limit();
        send(1'b1, text_byte());
        repeat (134) send(1'b0, text_byte());
        send(1'b0, ChQuote);
        drain();
    endtask

    task automatic test_limit_edges();
        set_limit(16'd0);
        send(1'b1, 8'h61);
        send(1'b1, 8'h00);
        set_limit(16'hFFFF);
        send(1'b1, 8'h7F);
        // lowered mid-value, applies at the next character
        set_limit(16'd1);
        send(1'b0, 8'h80);
        send_text(1'b1, "\\u20ACx");
        drain();
    endtask

    task automatic test_random(input int idle, input int stall, input logic [LimitW-1:0] lim,
                               input int goal);
        int first;
        set_limit(lim);
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        first = n_sent;
        while (n_sent - first < goal) send_random_value(8);
        drain();
    endtask

    task automatic test_backpressure();
        int first;
        set_limit(16'hFFFF);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_cycles   = 150;
        first = n_sent;
        while (n_sent - first < 30) send_random_value(6);
        drain();
    endtask

    // receiver side
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected result byte %0h end %0b", out_if.out_byte,
                                 out_if.is_end));
            end else begin
                want = decoded_q.pop_front();
                if (out_if.out_byte !== want.data)
                    report($sformatf("out_byte %0h, wanted %0h", out_if.out_byte, want.data));
                if (out_if.is_end !== want.is_end)
                    report($sformatf("is_end %0b, wanted %0b", out_if.is_end, want.is_end));
                if (out_if.end_reason !== want.reason)
                    report($sformatf("end_reason %0d, wanted %0d", out_if.end_reason,
                                     want.reason));
                if (out_if.last !== want.last)
                    report($sformatf("last %0b, wanted %0b", out_if.last, want.last));
            end
        end
    end

    initial begin
        errors          = 0;
        n_sent          = 0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        hold_cycles     = 0;
        dec_mode        = MODE_DONE;
        dec_code        = '0;
        dec_hexn        = '0;
        dec_count       = '0;
        dec_limit       = LimitReset;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.start_req = 1'b0;
        in_if.in_byte   = 8'h00;
        out_if.ready    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_default_limit();
        test_limit_edges();
        test_random(0, 0, 16'hFFFF, 30);
        test_random(58, 0, 16'd6, 30);
        test_random(0, 58, 16'($urandom_range(0, 30)), 30);
        test_random(16, 16, 16'($urandom_range(0, 30)), 30);
        test_backpressure();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ json_string_unescape_utf8_core.f @@
sv/jsu_pkg.sv
sv/jsu_if.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8_core.sv
tb/tb.sv
